>>> rtl/lbs_pkg.sv
// Shared types and constants for the linear blend skinning block.
package lbs_pkg;

    localparam int WORD_W   = 32;
    localparam int ACC_W    = 48;
    localparam int WEIGHT_W = 18;
    localparam int WFRAC    = 16;
    localparam int FRAC_BITS = 16;
    localparam int WORDS_PER_BONE = 12;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_INFL = 2'd1,
        ACT_LAST = 2'd2,
        ACT_PASS = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         bone_index;
        logic [3:0]         element_index;
        logic signed [31:0] matrix_word;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
        logic [17:0]        weight;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_norm_x;
        logic signed [31:0] out_norm_y;
        logic signed [31:0] out_norm_z;
    } out_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        if (x > 50'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (x < -50'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
        if (x > 49'sh0_7fff_ffff_ffff) begin
            sat48 = 48'sh7fff_ffff_ffff;
        end else if (x < -49'sh0_8000_0000_0000) begin
            sat48 = 48'sh8000_0000_0000;
        end else begin
            sat48 = x[47:0];
        end
    endfunction

endpackage

>>> rtl/lbs_ram.sv
// Generic single-port-write, registered-read RAM.
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/linear_blend_vertex_skinning_top.sv
// Linear blend skinning top level: matrix store, sequencer and accumulators.
// Loads, pass-throughs and skipped influences end on acceptance; a pass-through or
// skipped last influence is valid next cycle. Valid influence: transfer, 12 word
// reads on one registered-read port, 6 weighting steps, result if last influence.
// Input stalls while a result waits unaccepted in the output register.
// Synchronous active-low reset clears control, accumulators and bone_count.
module linear_blend_vertex_skinning_top #(
    parameter int MAX_BONES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lbs_pkg::in_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lbs_pkg::out_item_t m_data,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_wdata
);
    import lbs_pkg::*;

    localparam int DEPTH = MAX_BONES * WORDS_PER_BONE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAT  = 3'b010,
        ST_WGT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [8:0] bone_count_reg;
    logic [3:0] cnt_reg;           // element / weighting step counter
    logic signed [ACC_W-1:0] pacc_reg [3];
    logic signed [ACC_W-1:0] nacc_reg [3];
    logic signed [49:0] tp_reg [3];   // transformed position sums
    logic signed [49:0] tn_reg [3];   // transformed normal sums
    logic [3:0] rd_idx_reg;          // element whose data arrives this cycle
    logic rd_vld_reg;
    out_item_t out_reg;
    logic out_vld_reg;

    // ---- matrix store ----
    logic [AW-1:0] waddr, raddr;
    logic [31:0] rdata;
    logic ld_ok, we;
    logic [3:0] widx;

    assign widx  = 4'(({2'b0, s_data.element_index[3:2]} * 4'd3) + {2'b0, s_data.element_index[1:0]});
    assign ld_ok = (s_data.element_index[1:0] != 2'd3) && (32'(s_data.bone_index) < 32'(MAX_BONES));
    assign we    = s_valid && s_ready && (s_data.action == ACT_LOAD) && ld_ok;
    assign waddr = AW'(32'(s_data.bone_index) * WORDS_PER_BONE + 32'(widx));
    assign raddr = AW'(32'(item_reg.bone_index) * WORDS_PER_BONE + 32'(cnt_reg));

    lbs_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(s_data.matrix_word),
        .raddr(raddr), .rdata(rdata)
    );

    // ---- shared multiplier ----
    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] prod;
    logic signed [31:0] vec_sel;
    logic [1:0] col, row;

    // element -> matrix column by compares, row is what remains
    always_comb begin
        if (rd_idx_reg >= 4'd9) begin
            col = 2'd3;
        end else if (rd_idx_reg >= 4'd6) begin
            col = 2'd2;
        end else if (rd_idx_reg >= 4'd3) begin
            col = 2'd1;
        end else begin
            col = 2'd0;
        end
        row = 2'(rd_idx_reg - {1'b0, col, 1'b0} - {2'b0, col});
    end

    always_comb begin
        case (col)
            2'd0: vec_sel = item_reg.pos_x;
            2'd1: vec_sel = item_reg.pos_y;
            default: vec_sel = item_reg.pos_z;
        endcase
    end

    // weighting step k: 0..2 position rows, 3..5 normal rows
    logic signed [31:0] wsat;
    always_comb begin
        case (cnt_reg)
            4'd0: wsat = sat32(tp_reg[0]);
            4'd1: wsat = sat32(tp_reg[1]);
            4'd2: wsat = sat32(tp_reg[2]);
            4'd3: wsat = sat32(tn_reg[0]);
            4'd4: wsat = sat32(tn_reg[1]);
            default: wsat = sat32(tn_reg[2]);
        endcase
    end

    always_comb begin
        if (state_reg == ST_WGT) begin
            mul_a = wsat;
            mul_b = {15'b0, item_reg.weight};
        end else begin
            mul_a = $signed(rdata);
            mul_b = 33'(vec_sel);
        end
        prod = 65'(mul_a * mul_b);
    end

    logic signed [31:0] nvec;
    always_comb begin
        case (col)
            2'd0: nvec = item_reg.norm_x;
            2'd1: nvec = item_reg.norm_y;
            default: nvec = item_reg.norm_z;
        endcase
    end
    // normal product uses a second multiplier in the read phase
    logic signed [63:0] nprod;
    assign nprod = $signed(rdata) * nvec;

    // ---- control ----
    logic accept, bone_ok, is_last;
    assign s_ready = (state_reg == ST_IDLE) && !(out_vld_reg && !m_ready);
    assign accept  = s_valid && s_ready;
    assign bone_ok = (9'(s_data.bone_index) < bone_count_reg)
                  && (32'(s_data.bone_index) < 32'(MAX_BONES));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.action == ACT_INFL || s_data.action == ACT_LAST)
                    && bone_ok) begin
                    state_next = ST_MAT;
                end
            end
            ST_MAT: begin
                if (rd_vld_reg && rd_idx_reg == 4'd11) begin
                    state_next = ST_WGT;
                end
            end
            ST_WGT: begin
                if (cnt_reg == 4'd5) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // final result from accumulators (after last update)
    function automatic out_item_t make_out(
        input logic signed [ACC_W-1:0] p0, p1, p2, n0, n1, n2,
        input in_item_t it);
        logic zn;
        zn = (n0 == '0) && (n1 == '0) && (n2 == '0);
        make_out.out_pos_x  = sat32(50'(p0));
        make_out.out_pos_y  = sat32(50'(p1));
        make_out.out_pos_z  = sat32(50'(p2));
        make_out.out_norm_x = zn ? it.norm_x : sat32(50'(n0));
        make_out.out_norm_y = zn ? it.norm_y : sat32(50'(n1));
        make_out.out_norm_z = zn ? it.norm_z : sat32(50'(n2));
    endfunction

    logic signed [ACC_W-1:0] wterm;
    assign wterm = ACC_W'(prod >>> WFRAC);

    logic signed [ACC_W-1:0] pacc_next [3];
    logic signed [ACC_W-1:0] nacc_next [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pacc_next[i] = pacc_reg[i];
            nacc_next[i] = nacc_reg[i];
        end
        if (state_reg == ST_WGT) begin
            case (cnt_reg)
                4'd0: pacc_next[0] = sat48(49'(pacc_reg[0]) + 49'(wterm));
                4'd1: pacc_next[1] = sat48(49'(pacc_reg[1]) + 49'(wterm));
                4'd2: pacc_next[2] = sat48(49'(pacc_reg[2]) + 49'(wterm));
                4'd3: nacc_next[0] = sat48(49'(nacc_reg[0]) + 49'(wterm));
                4'd4: nacc_next[1] = sat48(49'(nacc_reg[1]) + 49'(wterm));
                default: nacc_next[2] = sat48(49'(nacc_reg[2]) + 49'(wterm));
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            bone_count_reg <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            out_vld_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                pacc_reg[i] <= '0;
                nacc_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                bone_count_reg <= cfg_wdata;
            end
            if (out_vld_reg && m_ready) begin
                out_vld_reg <= 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
                pacc_reg[i] <= pacc_next[i];
                nacc_reg[i] <= nacc_next[i];
            end
            rd_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (accept) begin
                        item_reg <= s_data;
                        for (int i = 0; i < 3; i++) begin
                            tp_reg[i] <= '0;
                            tn_reg[i] <= '0;
                        end
                        if (s_data.action == ACT_PASS) begin
                            out_reg.out_pos_x  <= s_data.pos_x;
                            out_reg.out_pos_y  <= s_data.pos_y;
                            out_reg.out_pos_z  <= s_data.pos_z;
                            out_reg.out_norm_x <= s_data.norm_x;
                            out_reg.out_norm_y <= s_data.norm_y;
                            out_reg.out_norm_z <= s_data.norm_z;
                            out_vld_reg <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                pacc_reg[i] <= '0;
                                nacc_reg[i] <= '0;
                            end
                        end else if (s_data.action == ACT_LAST && !bone_ok) begin
                            out_reg     <= make_out(pacc_reg[0], pacc_reg[1], pacc_reg[2],
                                                    nacc_reg[0], nacc_reg[1], nacc_reg[2],
                                                    s_data);
                            out_vld_reg <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                pacc_reg[i] <= '0;
                                nacc_reg[i] <= '0;
                            end
                        end
                    end
                end
                ST_MAT: begin
                    if (cnt_reg != 4'd12) begin
                        cnt_reg    <= cnt_reg + 4'd1;
                        rd_vld_reg <= 1'b1;
                        rd_idx_reg <= cnt_reg;
                    end
                    if (rd_vld_reg) begin
                        if (rd_idx_reg < 4'd9) begin
                            tp_reg[row] <= tp_reg[row] + 50'(prod >>> FRAC_BITS);
                            tn_reg[row] <= tn_reg[row] + 50'(nprod >>> FRAC_BITS);
                        end else begin
                            tp_reg[row] <= tp_reg[row] + 50'($signed(rdata));
                        end
                        if (rd_idx_reg == 4'd11) begin
                            cnt_reg <= '0;
                        end
                    end
                end
                ST_WGT: begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd5 && item_reg.action == ACT_LAST) begin
                        out_reg     <= make_out(pacc_next[0], pacc_next[1], pacc_next[2],
                                                nacc_next[0], nacc_next[1], nacc_next[2],
                                                item_reg);
                        out_vld_reg <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            pacc_reg[i] <= '0;
                            nacc_reg[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // busy states never accept
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    // result must hold until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data))) else $error("result dropped");
    // weighting step counter stays within 0..5
    a_wgt_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WGT) |-> (cnt_reg <= 4'd5)) else $error("weight count overrun");
endmodule
